// ===== sv/mcg_pkg.sv =====
package mcg_pkg;

	localparam int SEQ_WIDTH_DEF     = 32;
	localparam int PAYLOAD_WIDTH_DEF = 48;
	localparam int STATUS_WIDTH      = 32;
	localparam int MAX_RESULTS       = 4;
	localparam int CNT_WIDTH         = $clog2(MAX_RESULTS + 1);
	localparam int IDX_WIDTH         = $clog2(MAX_RESULTS);
	localparam int ATT_WIDTH         = 4;

	localparam logic [ATT_WIDTH-1:0] ATTEMPTS_RESET = 4'd3;
	localparam logic [ATT_WIDTH-1:0] ATTEMPTS_SAT   = 4'd15;

	localparam logic CMD_MOVE = 1'b0;
	localparam logic CMD_STOP = 1'b1;

	typedef enum logic [2:0] {
		MODE_MOVE     = 3'd0,
		MODE_STOP     = 3'd1,
		MODE_DISCARD  = 3'd2,
		MODE_CLR_FLT  = 3'd3,
		MODE_SHUTDOWN = 3'd4,
		MODE_DONE     = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		RK_REPLY = 2'd0,
		RK_DONE  = 2'd1,
		RK_ISSUE = 2'd2
	} rkind_t;

	typedef enum logic [2:0] {
		OC_OK         = 3'd0,
		OC_ERROR      = 3'd1,
		OC_EXCEPTION  = 3'd2,
		OC_SUPERSEDED = 3'd3,
		OC_PREEMPTED  = 3'd4,
		OC_DISCARDED  = 3'd5
	} outcome_t;

	typedef enum logic [1:0] {
		STOP_CONFIRMED = 2'd0,
		STOP_PENDING   = 2'd1,
		STOP_FAILED    = 2'd2
	} stop_t;

	typedef enum logic [1:0] {
		FL_NONE = 2'd0,
		FL_MOVE = 2'd1,
		FL_STOP = 2'd2
	} flight_t;

	typedef struct packed {
		stop_t stop_state;
		logic  fault;
		logic  busy;
		logic  halted;
	} step_status_t;

endpackage

// ===== sv/motion_command_gate.sv =====
// channel | handshake           | payload
// in      | in_valid / in_ready | mode, move_payload, backend_status, backend_exception
// out     | out_valid/out_ready | result_kind .. last (one result item per transfer)
// cfg     | cfg_wen             | cfg_wdata (max shutdown stop attempts)
//
// an input item is decoded combinationally into a batch of one to four result items
// results leave one per cycle while out_ready allows, from the batch register through the output register
// an item producing n results takes n output transfers; the single output port sets this rate
// out_ready low holds a full output register and the batch, and with it the input
// a new item is taken in the cycle the last result of the previous batch moves out
// arst_n clears all control and command state; max attempts resets to 3
module motion_command_gate
	import mcg_pkg::*;
#(
	parameter int SEQ_WIDTH     = SEQ_WIDTH_DEF,
	parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           cfg_wen,
	input  logic [ATT_WIDTH-1:0]           cfg_wdata,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [2:0]                     mode,
	input  logic [PAYLOAD_WIDTH-1:0]       move_payload,
	input  logic signed [STATUS_WIDTH-1:0] backend_status,
	input  logic                           backend_exception,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     result_kind,
	output logic                           accepted,
	output logic [SEQ_WIDTH-1:0]           sequence_res,
	output logic                           command_kind,
	output logic [2:0]                     outcome,
	output logic signed [STATUS_WIDTH-1:0] reported_status,
	output logic [PAYLOAD_WIDTH-1:0]       out_payload,
	output logic [1:0]                     stop_status,
	output logic                           fault_flag,
	output logic                           busy_res,
	output logic                           halted,
	output logic                           last
);

	typedef struct packed {
		rkind_t                         kind;
		logic                           acc;
		logic [SEQ_WIDTH-1:0]           seq;
		logic                           cmd;
		outcome_t                       oc;
		logic signed [STATUS_WIDTH-1:0] status;
		logic [PAYLOAD_WIDTH-1:0]       pay;
	} rec_t;

	function automatic rec_t mk_rec(input rkind_t kind, input logic acc,
			input logic [SEQ_WIDTH-1:0] seq, input logic cmd, input outcome_t oc,
			input logic signed [STATUS_WIDTH-1:0] status,
			input logic [PAYLOAD_WIDTH-1:0] pay);
		rec_t r;
		r.kind   = kind;
		r.acc    = acc;
		r.seq    = seq;
		r.cmd    = cmd;
		r.oc     = oc;
		r.status = status;
		r.pay    = pay;
		return r;
	endfunction

	// command state
	logic [ATT_WIDTH-1:0]     max_att_q;
	logic [SEQ_WIDTH-1:0]     next_seq_q;
	logic                     mv_valid_q;
	logic [SEQ_WIDTH-1:0]     mv_seq_q;
	logic [PAYLOAD_WIDTH-1:0] mv_pay_q;
	logic                     st_valid_q;
	logic [SEQ_WIDTH-1:0]     st_seq_q;
	flight_t                  fl_kind_q;
	logic [SEQ_WIDTH-1:0]     fl_seq_q;
	logic [PAYLOAD_WIDTH-1:0] fl_pay_q;
	stop_t                    stop_state_q;
	logic                     fault_q;
	logic                     accepting_q;
	logic                     shutdown_q;
	logic [SEQ_WIDTH-1:0]     sd_seq_q;
	logic [ATT_WIDTH-1:0]     attempts_q;
	logic                     halted_q;

	// next state
	logic [SEQ_WIDTH-1:0]     n_next_seq;
	logic                     n_mv_valid;
	logic [SEQ_WIDTH-1:0]     n_mv_seq;
	logic [PAYLOAD_WIDTH-1:0] n_mv_pay;
	logic                     n_st_valid;
	logic [SEQ_WIDTH-1:0]     n_st_seq;
	flight_t                  n_fl_kind;
	logic [SEQ_WIDTH-1:0]     n_fl_seq;
	logic [PAYLOAD_WIDTH-1:0] n_fl_pay;
	stop_t                    n_stop_state;
	logic                     n_fault;
	logic                     n_accepting;
	logic                     n_shutdown;
	logic [SEQ_WIDTH-1:0]     n_sd_seq;
	logic [ATT_WIDTH-1:0]     n_attempts;
	logic                     n_halted;

	rec_t                     recs [MAX_RESULTS];
	logic [CNT_WIDTH-1:0]     cnt;

	// result batch and output register
	rec_t                     recs_q [MAX_RESULTS];
	logic [CNT_WIDTH-1:0]     bcnt_q;
	logic [IDX_WIDTH-1:0]     bidx_q;
	step_status_t             bstat_q;
	rec_t                     out_rec_q;
	step_status_t             out_stat_q;
	logic                     out_last_q;
	logic                     out_valid_q;

	logic                     out_load;
	logic                     move_out;
	logic                     in_acc;

	always_comb begin
		logic [SEQ_WIDTH-1:0]           s;
		logic [SEQ_WIDTH-1:0]           dseq;
		logic signed [STATUS_WIDTH-1:0] st;
		outcome_t                       oc;
		logic                           ok;
		logic                           rep_acc;
		logic [SEQ_WIDTH-1:0]           rep_seq;

		n_next_seq   = next_seq_q;
		n_mv_valid   = mv_valid_q;
		n_mv_seq     = mv_seq_q;
		n_mv_pay     = mv_pay_q;
		n_st_valid   = st_valid_q;
		n_st_seq     = st_seq_q;
		n_fl_kind    = fl_kind_q;
		n_fl_seq     = fl_seq_q;
		n_fl_pay     = fl_pay_q;
		n_stop_state = stop_state_q;
		n_fault      = fault_q;
		n_accepting  = accepting_q;
		n_shutdown   = shutdown_q;
		n_sd_seq     = sd_seq_q;
		n_attempts   = attempts_q;
		n_halted     = halted_q;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			recs[i] = '0;
		end
		cnt     = '0;
		s       = '0;
		dseq    = '0;
		st      = '0;
		oc      = OC_OK;
		ok      = 1'b0;
		rep_acc = 1'b0;
		rep_seq = '0;

		if (!halted_q) begin
			case (mode)
				MODE_MOVE: begin
					if (accepting_q && !fault_q && stop_state_q == STOP_CONFIRMED) begin
						s = n_next_seq;
						n_next_seq = n_next_seq + 1'b1;
						if (n_mv_valid) begin
							recs[cnt[IDX_WIDTH-1:0]] = mk_rec(RK_DONE, 1'b0, n_mv_seq,
								CMD_MOVE, OC_SUPERSEDED, '0, n_mv_pay);
							cnt = cnt + 1'b1;
						end
						n_mv_valid = 1'b1;
						n_mv_seq   = s;
						n_mv_pay   = move_payload;
						rep_acc    = 1'b1;
						rep_seq    = s;
					end
				end
				MODE_STOP: begin
					if (!accepting_q) begin
						rep_acc = 1'b0;
					end else if (st_valid_q) begin
						rep_acc = 1'b1;
						rep_seq = st_seq_q;
					end else if (fl_kind_q == FL_STOP) begin
						rep_acc = 1'b1;
						rep_seq = fl_seq_q;
					end else begin
						if (n_mv_valid) begin
							recs[cnt[IDX_WIDTH-1:0]] = mk_rec(RK_DONE, 1'b0, n_mv_seq,
								CMD_MOVE, OC_PREEMPTED, '0, n_mv_pay);
							cnt = cnt + 1'b1;
							n_mv_valid = 1'b0;
						end
						s = n_next_seq;
						n_next_seq   = n_next_seq + 1'b1;
						n_st_valid   = 1'b1;
						n_st_seq     = s;
						n_stop_state = STOP_PENDING;
						rep_acc      = 1'b1;
						rep_seq      = s;
					end
				end
				MODE_DISCARD: begin
					if (n_mv_valid) begin
						recs[cnt[IDX_WIDTH-1:0]] = mk_rec(RK_DONE, 1'b0, n_mv_seq,
							CMD_MOVE, OC_DISCARDED, '0, n_mv_pay);
						cnt = cnt + 1'b1;
						n_mv_valid = 1'b0;
						rep_acc    = 1'b1;
					end
				end
				MODE_CLR_FLT: begin
					if (accepting_q && stop_state_q == STOP_CONFIRMED) begin
						n_fault = 1'b0;
						rep_acc = 1'b1;
					end
				end
				MODE_SHUTDOWN: begin
					if (shutdown_q) begin
						rep_seq = sd_seq_q;
					end else begin
						n_accepting = 1'b0;
						n_shutdown  = 1'b1;
						if (n_mv_valid) begin
							recs[cnt[IDX_WIDTH-1:0]] = mk_rec(RK_DONE, 1'b0, n_mv_seq,
								CMD_MOVE, OC_PREEMPTED, '0, n_mv_pay);
							cnt = cnt + 1'b1;
							n_mv_valid = 1'b0;
						end
						if (st_valid_q) begin
							n_sd_seq = st_seq_q;
						end else if (fl_kind_q == FL_STOP) begin
							n_sd_seq = fl_seq_q;
						end else begin
							s = n_next_seq;
							n_next_seq   = n_next_seq + 1'b1;
							n_st_valid   = 1'b1;
							n_st_seq     = s;
							n_sd_seq     = s;
							n_stop_state = STOP_PENDING;
						end
						rep_acc = 1'b1;
						rep_seq = n_sd_seq;
					end
				end
				MODE_DONE: begin
					if (fl_kind_q != FL_NONE) begin
						dseq = fl_seq_q;
						if (backend_exception) begin
							st = '1;
							oc = OC_EXCEPTION;
						end else begin
							st = backend_status;
							oc = (backend_status == '0) ? OC_OK : OC_ERROR;
						end
						ok = (oc == OC_OK);
						n_fl_kind = FL_NONE;
						if (fl_kind_q == FL_STOP) begin
							recs[cnt[IDX_WIDTH-1:0]] = mk_rec(RK_DONE, 1'b0, dseq,
								CMD_STOP, oc, st, '0);
							cnt = cnt + 1'b1;
							n_stop_state = ok ? STOP_CONFIRMED : STOP_FAILED;
							if (shutdown_q && sd_seq_q == dseq) begin
								if (n_attempts < ATTEMPTS_SAT) begin
									n_attempts = n_attempts + 1'b1;
								end
								if (ok || n_attempts >= max_att_q) begin
									n_halted = 1'b1;
								end else begin
									s = n_next_seq;
									n_next_seq   = n_next_seq + 1'b1;
									n_st_valid   = 1'b1;
									n_st_seq     = s;
									n_sd_seq     = s;
									n_stop_state = STOP_PENDING;
								end
							end
						end else begin
							recs[cnt[IDX_WIDTH-1:0]] = mk_rec(RK_DONE, 1'b0, dseq,
								CMD_MOVE, oc, st, fl_pay_q);
							cnt = cnt + 1'b1;
							if (!ok) begin
								n_fault = 1'b1;
								if (n_mv_valid) begin
									recs[cnt[IDX_WIDTH-1:0]] = mk_rec(RK_DONE, 1'b0,
										n_mv_seq, CMD_MOVE, OC_PREEMPTED, '0, n_mv_pay);
									cnt = cnt + 1'b1;
									n_mv_valid = 1'b0;
								end
								if (!n_st_valid) begin
									s = n_next_seq;
									n_next_seq = n_next_seq + 1'b1;
									n_st_valid = 1'b1;
									n_st_seq   = s;
								end
								n_stop_state = STOP_PENDING;
							end
						end
						rep_acc = 1'b1;
						rep_seq = dseq;
					end
				end
				default: begin
					rep_acc = 1'b0;
				end
			endcase

			// hand the next command to the backend once it is free
			if (n_fl_kind == FL_NONE && !n_halted) begin
				if (n_st_valid) begin
					n_fl_kind  = FL_STOP;
					n_fl_seq   = n_st_seq;
					n_fl_pay   = '0;
					n_st_valid = 1'b0;
					recs[cnt[IDX_WIDTH-1:0]] = mk_rec(RK_ISSUE, 1'b0, n_st_seq,
						CMD_STOP, OC_OK, '0, '0);
					cnt = cnt + 1'b1;
				end else if (n_mv_valid) begin
					n_fl_kind  = FL_MOVE;
					n_fl_seq   = n_mv_seq;
					n_fl_pay   = n_mv_pay;
					n_mv_valid = 1'b0;
					recs[cnt[IDX_WIDTH-1:0]] = mk_rec(RK_ISSUE, 1'b0, n_mv_seq,
						CMD_MOVE, OC_OK, '0, n_mv_pay);
					cnt = cnt + 1'b1;
				end
			end
		end

		recs[cnt[IDX_WIDTH-1:0]] = mk_rec(RK_REPLY, rep_acc, rep_seq, CMD_MOVE, OC_OK,
			'0, '0);
		cnt = cnt + 1'b1;
	end

	assign out_load = !out_valid_q || out_ready;
	assign move_out = (bcnt_q != '0) && out_load;
	assign in_ready = (bcnt_q == '0) || (bcnt_q == CNT_WIDTH'(1) && out_load);
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_att_q    <= ATTEMPTS_RESET;
			next_seq_q   <= SEQ_WIDTH'(1);
			mv_valid_q   <= 1'b0;
			mv_seq_q     <= '0;
			mv_pay_q     <= '0;
			st_valid_q   <= 1'b0;
			st_seq_q     <= '0;
			fl_kind_q    <= FL_NONE;
			fl_seq_q     <= '0;
			fl_pay_q     <= '0;
			stop_state_q <= STOP_CONFIRMED;
			fault_q      <= 1'b0;
			accepting_q  <= 1'b1;
			shutdown_q   <= 1'b0;
			sd_seq_q     <= '0;
			attempts_q   <= '0;
			halted_q     <= 1'b0;
		end else begin
			if (cfg_wen) begin
				max_att_q <= cfg_wdata;
			end
			if (in_acc) begin
				next_seq_q   <= n_next_seq;
				mv_valid_q   <= n_mv_valid;
				mv_seq_q     <= n_mv_seq;
				mv_pay_q     <= n_mv_pay;
				st_valid_q   <= n_st_valid;
				st_seq_q     <= n_st_seq;
				fl_kind_q    <= n_fl_kind;
				fl_seq_q     <= n_fl_seq;
				fl_pay_q     <= n_fl_pay;
				stop_state_q <= n_stop_state;
				fault_q      <= n_fault;
				accepting_q  <= n_accepting;
				shutdown_q   <= n_shutdown;
				sd_seq_q     <= n_sd_seq;
				attempts_q   <= n_attempts;
				halted_q     <= n_halted;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q      <= '0;
			bidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				bcnt_q <= cnt;
				bidx_q <= '0;
			end else if (move_out) begin
				bcnt_q <= bcnt_q - 1'b1;
				bidx_q <= bidx_q + 1'b1;
			end
			if (move_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			recs_q  <= recs;
			bstat_q <= '{stop_state: n_stop_state, fault: n_fault,
				busy: (n_fl_kind != FL_NONE), halted: n_halted};
		end
		if (move_out) begin
			out_rec_q  <= recs_q[bidx_q];
			out_stat_q <= bstat_q;
			out_last_q <= (bcnt_q == CNT_WIDTH'(1));
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = out_rec_q.kind;
	assign accepted        = out_rec_q.acc;
	assign sequence_res    = out_rec_q.seq;
	assign command_kind    = out_rec_q.cmd;
	assign outcome         = out_rec_q.oc;
	assign reported_status = out_rec_q.status;
	assign out_payload     = out_rec_q.pay;
	assign stop_status     = out_stat_q.stop_state;
	assign fault_flag      = out_stat_q.fault;
	assign busy_res        = out_stat_q.busy;
	assign halted          = out_stat_q.halted;
	assign last            = out_last_q;

`ifndef NO_ASSERTIONS
	a_batch_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> bcnt_q != '0)
		else $error("accepted item left no results");

	a_batch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bcnt_q <= CNT_WIDTH'(MAX_RESULTS))
		else $error("result batch overflow");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt was released");

	a_idle_slots_empty: assert property (@(posedge clk) disable iff (!arst_n)
		fl_kind_q == FL_NONE && !halted_q |-> !mv_valid_q && !st_valid_q)
		else $error("command waiting while backend idle");
`endif

endmodule

// ===== sim/motion_command_gate_checker.sv =====
`timescale 1ns / 100ps
module motion_command_gate_checker
	import mcg_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [ATT_WIDTH-1:0]           cfg_wdata,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [2:0]                     mode,
	input  logic [PAYLOAD_WIDTH_DEF-1:0]   move_payload,
	input  logic signed [STATUS_WIDTH-1:0] backend_status,
	input  logic                           backend_exception,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [1:0]                     result_kind,
	input  logic                           accepted,
	input  logic [SEQ_WIDTH_DEF-1:0]       sequence_res,
	input  logic                           command_kind,
	input  logic [2:0]                     outcome,
	input  logic signed [STATUS_WIDTH-1:0] reported_status,
	input  logic [PAYLOAD_WIDTH_DEF-1:0]   out_payload,
	input  logic [1:0]                     stop_status,
	input  logic                           fault_flag,
	input  logic                           busy_res,
	input  logic                           halted,
	input  logic                           last,
	output int                             failures,
	output int                             outstanding
);

	typedef logic [SEQ_WIDTH_DEF-1:0]       seq_t;
	typedef logic [PAYLOAD_WIDTH_DEF-1:0]   pay_t;
	typedef logic signed [STATUS_WIDTH-1:0] status_t;

	typedef struct packed {
		rkind_t   kind;
		logic     acc;
		seq_t     seq;
		logic     cmd;
		outcome_t oc;
		status_t  status;
		pay_t     pay;
		stop_t    stop;
		logic     fault;
		logic     busy;
		logic     halt;
		logic     last;
	} gate_result_t;

	gate_result_t due_results[$];
	gate_result_t step_results[$];

	seq_t                 seq_next;
	logic                 move_held;
	seq_t                 move_held_seq;
	pay_t                 move_held_pay;
	logic                 stop_held;
	seq_t                 stop_held_seq;
	flight_t              in_flight;
	seq_t                 flight_seq;
	pay_t                 flight_pay;
	stop_t                stop_state;
	logic                 fault_latched;
	logic                 taking_requests;
	logic                 shutting_down;
	seq_t                 shutdown_stop_seq;
	logic [ATT_WIDTH-1:0] stop_attempts;
	logic [ATT_WIDTH-1:0] attempt_limit;
	logic                 gate_halted;

	task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
		failures++;
	endtask

	task automatic clear_gate();
		seq_next          = 1;
		move_held         = 1'b0;
		move_held_seq     = '0;
		move_held_pay     = '0;
		stop_held         = 1'b0;
		stop_held_seq     = '0;
		in_flight         = FL_NONE;
		flight_seq        = '0;
		flight_pay        = '0;
		stop_state        = STOP_CONFIRMED;
		fault_latched     = 1'b0;
		taking_requests   = 1'b1;
		shutting_down     = 1'b0;
		shutdown_stop_seq = '0;
		stop_attempts     = '0;
		attempt_limit     = ATTEMPTS_RESET;
		gate_halted       = 1'b0;
	endtask

	function automatic seq_t claim_seq();
		seq_t s;
		s = seq_next;
		seq_next = seq_next + 1'b1;
		return s;
	endfunction

	task automatic add_result(input rkind_t kind, input logic acc, input seq_t seq,
			input logic cmd, input outcome_t oc, input status_t status, input pay_t pay);
		gate_result_t r;
		r = '0;
		r.kind   = kind;
		r.acc    = acc;
		r.seq    = seq;
		r.cmd    = cmd;
		r.oc     = oc;
		r.status = status;
		r.pay    = pay;
		step_results = {step_results, r};
	endtask

	task automatic reply(input logic acc, input seq_t seq);
		add_result(RK_REPLY, acc, seq, CMD_MOVE, OC_OK, '0, '0);
	endtask

	task automatic drop_held_move(input outcome_t oc);
		if (move_held) begin
			add_result(RK_DONE, 1'b0, move_held_seq, CMD_MOVE, oc, '0, move_held_pay);
			move_held = 1'b0;
		end
	endtask

	task automatic launch();
		if (in_flight == FL_NONE && !gate_halted) begin
			if (stop_held) begin
				in_flight  = FL_STOP;
				flight_seq = stop_held_seq;
				flight_pay = '0;
				stop_held  = 1'b0;
				add_result(RK_ISSUE, 1'b0, flight_seq, CMD_STOP, OC_OK, '0, '0);
			end else if (move_held) begin
				in_flight  = FL_MOVE;
				flight_seq = move_held_seq;
				flight_pay = move_held_pay;
				move_held  = 1'b0;
				add_result(RK_ISSUE, 1'b0, flight_seq, CMD_MOVE, OC_OK, '0, flight_pay);
			end
		end
	endtask

	task automatic queue_stop();
		stop_held     = 1'b1;
		stop_held_seq = claim_seq();
	endtask

	task automatic finish_flight(input status_t status, input logic threw);
		status_t  st;
		outcome_t oc;
		logic     ok;
		seq_t     seq;
		flight_t  kind;
		st   = status;
		seq  = flight_seq;
		kind = in_flight;
		if (threw) begin
			st = -1;
			oc = OC_EXCEPTION;
		end else begin
			oc = (st == 0) ? OC_OK : OC_ERROR;
		end
		ok = (oc == OC_OK);
		in_flight = FL_NONE;
		if (kind == FL_STOP) begin
			add_result(RK_DONE, 1'b0, seq, CMD_STOP, oc, st, '0);
			stop_state = ok ? STOP_CONFIRMED : STOP_FAILED;
			if (shutting_down && shutdown_stop_seq == seq) begin
				if (stop_attempts < ATTEMPTS_SAT)
					stop_attempts = stop_attempts + 1'b1;
				if (ok || stop_attempts >= attempt_limit) begin
					gate_halted = 1'b1;
				end else begin
					queue_stop();
					shutdown_stop_seq = stop_held_seq;
					stop_state = STOP_PENDING;
				end
			end
		end else begin
			add_result(RK_DONE, 1'b0, seq, CMD_MOVE, oc, st, flight_pay);
			if (!ok) begin
				fault_latched = 1'b1;
				drop_held_move(OC_PREEMPTED);
				if (!stop_held)
					queue_stop();
				stop_state = STOP_PENDING;
			end
		end
		launch();
		reply(1'b1, seq);
	endtask

	task automatic advance_gate(input logic [2:0] m, input pay_t pay, input status_t status,
			input logic threw);
		seq_t s;
		logic dropped;
		if (gate_halted) begin
			reply(1'b0, '0);
		end else begin
			case (m)
				MODE_MOVE: begin
					if (!taking_requests || fault_latched || stop_state != STOP_CONFIRMED) begin
						reply(1'b0, '0);
					end else begin
						s = claim_seq();
						drop_held_move(OC_SUPERSEDED);
						move_held     = 1'b1;
						move_held_seq = s;
						move_held_pay = pay;
						launch();
						reply(1'b1, s);
					end
				end
				MODE_STOP: begin
					if (!taking_requests) begin
						reply(1'b0, '0);
					end else if (stop_held) begin
						reply(1'b1, stop_held_seq);
					end else if (in_flight == FL_STOP) begin
						reply(1'b1, flight_seq);
					end else begin
						drop_held_move(OC_PREEMPTED);
						queue_stop();
						stop_state = STOP_PENDING;
						s = stop_held_seq;
						launch();
						reply(1'b1, s);
					end
				end
				MODE_DISCARD: begin
					dropped = move_held;
					drop_held_move(OC_DISCARDED);
					reply(dropped, '0);
				end
				MODE_CLR_FLT: begin
					if (!taking_requests || stop_state != STOP_CONFIRMED) begin
						reply(1'b0, '0);
					end else begin
						fault_latched = 1'b0;
						reply(1'b1, '0);
					end
				end
				MODE_SHUTDOWN: begin
					if (shutting_down) begin
						reply(1'b0, shutdown_stop_seq);
					end else begin
						taking_requests = 1'b0;
						shutting_down   = 1'b1;
						drop_held_move(OC_PREEMPTED);
						if (stop_held) begin
							shutdown_stop_seq = stop_held_seq;
						end else if (in_flight == FL_STOP) begin
							shutdown_stop_seq = flight_seq;
						end else begin
							queue_stop();
							shutdown_stop_seq = stop_held_seq;
							stop_state = STOP_PENDING;
						end
						launch();
						reply(1'b1, shutdown_stop_seq);
					end
				end
				MODE_DONE: begin
					if (in_flight == FL_NONE)
						reply(1'b0, '0);
					else
						finish_flight(status, threw);
				end
				default: begin
					reply(1'b0, '0);
				end
			endcase
		end
		foreach (step_results[k]) begin
			step_results[k].stop  = stop_state;
			step_results[k].fault = fault_latched;
			step_results[k].busy  = (in_flight != FL_NONE);
			step_results[k].halt  = gate_halted;
			step_results[k].last  = (k == step_results.size() - 1);
			due_results = {due_results, step_results[k]};
		end
		step_results.delete();
	endtask

	task automatic check_result();
		gate_result_t want;
		if (due_results.size() == 0) begin
			flag("result with none due, result_kind", result_kind, '0);
		end else begin
			want = due_results[0];
			due_results.delete(0);
			if (result_kind !== want.kind)
				flag("result_kind", result_kind, want.kind);
			if (accepted !== want.acc)
				flag("accepted", accepted, want.acc);
			if (sequence_res !== want.seq)
				flag("sequence_res", sequence_res, want.seq);
			if (command_kind !== want.cmd)
				flag("command_kind", command_kind, want.cmd);
			if (outcome !== want.oc)
				flag("outcome", outcome, want.oc);
			if (reported_status !== want.status)
				flag("reported_status", reported_status, want.status);
			if (out_payload !== want.pay)
				flag("out_payload", out_payload, want.pay);
			if (stop_status !== want.stop)
				flag("stop_status", stop_status, want.stop);
			if (fault_flag !== want.fault)
				flag("fault_flag", fault_flag, want.fault);
			if (busy_res !== want.busy)
				flag("busy_res", busy_res, want.busy);
			if (halted !== want.halt)
				flag("halted", halted, want.halt);
			if (last !== want.last)
				flag("last", last, want.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_gate();
			due_results.delete();
			step_results.delete();
			failures    = 0;
			outstanding = 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				advance_gate(mode, move_payload, backend_status, backend_exception);
			if (cfg_wen)
				attempt_limit = cfg_wdata;
			outstanding = due_results.size();
		end
	end

endmodule

// ===== sim/motion_command_gate_test.sv =====
`timescale 1ns / 100ps
module motion_command_gate_test;
	import mcg_pkg::*;

	localparam logic [2:0] MODE_UNUSED_A = 3'd6;
	localparam logic [2:0] MODE_UNUSED_B = 3'd7;
	localparam int         CYCLE_LIMIT   = 300000;
	localparam int         PHASE_ITEMS   = 80;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_wen;
	logic [ATT_WIDTH-1:0]               cfg_wdata;
	logic                               in_valid;
	logic                               in_ready;
	logic [2:0]                         mode;
	logic [PAYLOAD_WIDTH_DEF-1:0]       move_payload;
	logic signed [STATUS_WIDTH-1:0]     backend_status;
	logic                               backend_exception;
	logic                               out_valid;
	logic                               out_ready;
	logic [1:0]                         result_kind;
	logic                               accepted;
	logic [SEQ_WIDTH_DEF-1:0]           sequence_res;
	logic                               command_kind;
	logic [2:0]                         outcome;
	logic signed [STATUS_WIDTH-1:0]     reported_status;
	logic [PAYLOAD_WIDTH_DEF-1:0]       out_payload;
	logic [1:0]                         stop_status;
	logic                               fault_flag;
	logic                               busy_res;
	logic                               halted;
	logic                               last;
	int                                 failures;
	int                                 outstanding;
	int                                 cycle_count = 0;
	logic                               steady_in = 1'b0;
	logic                               steady_out = 1'b0;

	always #5 clk = ~clk;

	motion_command_gate dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wen           (cfg_wen),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.move_payload      (move_payload),
		.backend_status    (backend_status),
		.backend_exception (backend_exception),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.result_kind       (result_kind),
		.accepted          (accepted),
		.sequence_res      (sequence_res),
		.command_kind      (command_kind),
		.outcome           (outcome),
		.reported_status   (reported_status),
		.out_payload       (out_payload),
		.stop_status       (stop_status),
		.fault_flag        (fault_flag),
		.busy_res          (busy_res),
		.halted            (halted),
		.last              (last)
	);

	motion_command_gate_checker gate_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wen           (cfg_wen),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.mode              (mode),
		.move_payload      (move_payload),
		.backend_status    (backend_status),
		.backend_exception (backend_exception),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.result_kind       (result_kind),
		.accepted          (accepted),
		.sequence_res      (sequence_res),
		.command_kind      (command_kind),
		.outcome           (outcome),
		.reported_status   (reported_status),
		.out_payload       (out_payload),
		.stop_status       (stop_status),
		.fault_flag        (fault_flag),
		.busy_res          (busy_res),
		.halted            (halted),
		.last              (last),
		.failures          (failures),
		.outstanding       (outstanding)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [PAYLOAD_WIDTH_DEF-1:0] rand_payload();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[PAYLOAD_WIDTH_DEF-1:0];
	endfunction

	task automatic offer(input logic [2:0] m, input logic [PAYLOAD_WIDTH_DEF-1:0] pay,
			input logic [STATUS_WIDTH-1:0] st, input logic exc);
		int gap;
		if ($urandom_range(0, 24) == 0)
			steady_in = !steady_in;
		gap = steady_in ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid          <= 1'b1;
		mode              <= m;
		move_payload      <= pay;
		backend_status    <= st;
		backend_exception <= exc;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic offer_random();
		int                      pick;
		logic [2:0]              m;
		logic [STATUS_WIDTH-1:0] st;
		logic                    exc;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			m = MODE_MOVE;
		else if (pick < 62)
			m = MODE_DONE;
		else if (pick < 72)
			m = MODE_STOP;
		else if (pick < 80)
			m = MODE_DISCARD;
		else if (pick < 94)
			m = MODE_CLR_FLT;
		else if (pick < 97)
			m = MODE_UNUSED_A;
		else
			m = MODE_UNUSED_B;
		st  = $urandom;
		exc = 1'($urandom_range(0, 1));
		if (m == MODE_DONE) begin
			exc = ($urandom_range(0, 11) == 0);
			if ($urandom_range(0, 9) < 8)
				st = '0;
		end
		offer(m, rand_payload(), st, exc);
	endtask

	task automatic write_attempt_limit(input logic [ATT_WIDTH-1:0] v);
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		int                      taken;
		int                      gap;
		out_ready = 1'b0;
		taken = 0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				taken++;
				if ($urandom_range(0, 24) == 0)
					steady_out = !steady_out;
				gap = steady_out ? 0 : $urandom_range(0, 7);
				// long hold-off so the block backs up into its input
				if (taken == 150 || taken == 600)
					gap = 90;
				if (gap > 0) begin
					@(negedge clk);
					out_ready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
					@(negedge clk);
					out_ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		logic [STATUS_WIDTH-1:0] st;
		arst_n            = 1'b0;
		cfg_wen           = 1'b0;
		cfg_wdata         = ATTEMPTS_RESET;
		in_valid          = 1'b0;
		mode              = MODE_MOVE;
		move_payload      = '0;
		backend_status    = '0;
		backend_exception = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_attempt_limit(ATTEMPTS_SAT);

		offer(MODE_DONE, '0, '0, 1'b0);
		offer(MODE_DISCARD, '1, '1, 1'b1);
		offer(MODE_CLR_FLT, '0, '0, 1'b0);
		offer(MODE_MOVE, '0, '0, 1'b0);
		offer(MODE_MOVE, '1, '0, 1'b0);
		offer(MODE_MOVE, 48'h5555_5555_5555, '0, 1'b0);
		offer(MODE_DISCARD, '0, '0, 1'b0);
		offer(MODE_MOVE, 48'hAAAA_AAAA_AAAA, '0, 1'b0);
		offer(MODE_DONE, '0, '0, 1'b0);
		offer(MODE_STOP, '0, '0, 1'b0);
		offer(MODE_STOP, '0, '0, 1'b0);
		offer(MODE_MOVE, '1, '0, 1'b0);
		// failed move latches the fault
		offer(MODE_DONE, '0, 32'h7FFF_FFFF, 1'b0);
		offer(MODE_STOP, '0, '0, 1'b0);
		offer(MODE_CLR_FLT, '0, '0, 1'b0);
		offer(MODE_DONE, '0, 32'h8000_0000, 1'b1);
		offer(MODE_MOVE, '0, '0, 1'b0);
		offer(MODE_STOP, '0, '0, 1'b0);
		offer(MODE_DONE, '0, '1, 1'b0);
		offer(MODE_STOP, '0, '0, 1'b0);
		offer(MODE_DONE, '0, '0, 1'b0);
		offer(MODE_CLR_FLT, '0, '0, 1'b0);
		offer(MODE_UNUSED_A, '0, '0, 1'b0);
		offer(MODE_UNUSED_B, '1, '1, 1'b1);
		offer(MODE_MOVE, '1, '0, 1'b0);

		for (int p = 0; p < 4; p++) begin
			if (p == 0)
				write_attempt_limit('0);
			else if (p == 1)
				write_attempt_limit(4'd1);
			else
				write_attempt_limit(ATT_WIDTH'($urandom_range(0, 15)));
			repeat (PHASE_ITEMS) offer_random();
		end

		// shutdown is terminal, so it closes the run
		write_attempt_limit(ATT_WIDTH'($urandom_range(0, 15)));
		repeat (6) offer_random();
		offer(MODE_SHUTDOWN, rand_payload(), $urandom, 1'b0);
		offer(MODE_SHUTDOWN, rand_payload(), $urandom, 1'b1);
		offer(MODE_STOP, rand_payload(), $urandom, 1'b0);
		offer(MODE_MOVE, rand_payload(), $urandom, 1'b0);
		offer(MODE_DISCARD, rand_payload(), $urandom, 1'b0);
		offer(MODE_CLR_FLT, rand_payload(), $urandom, 1'b0);
		repeat (20) begin
			st = ($urandom_range(0, 6) == 0) ? '0 : ($urandom | 32'h1);
			offer(MODE_DONE, rand_payload(), st, $urandom_range(0, 3) == 0);
		end
		write_attempt_limit(ATT_WIDTH'($urandom_range(0, 15)));
		offer(MODE_MOVE, rand_payload(), $urandom, 1'b0);
		offer(MODE_STOP, rand_payload(), $urandom, 1'b0);
		offer(MODE_SHUTDOWN, rand_payload(), $urandom, 1'b0);
		offer(MODE_DONE, rand_payload(), '0, 1'b0);
		offer(MODE_UNUSED_B, rand_payload(), $urandom, 1'b1);

		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
